// ----- sv/rwl_pkg.sv -----
// ----------------------------------------------------------------------------
// rwl_pkg: shared types and codes of the reader-writer lock arbiter
// Holds the item formats, the command and event codes, and the control and
// status bundles that pass between the sequencer, the holder and the queue.
// ----------------------------------------------------------------------------
package rwl_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_UNLOCK = 2'd2;

    localparam logic [2:0] EV_GRANTED   = 3'd0;
    localparam logic [2:0] EV_QUEUED    = 3'd1;
    localparam logic [2:0] EV_WOKEN     = 3'd2;
    localparam logic [2:0] EV_RELEASED  = 3'd3;
    localparam logic [2:0] EV_FULL      = 3'd4;
    localparam logic [2:0] EV_NO_HOLDER = 3'd5;
    localparam logic [2:0] EV_SATURATED = 3'd6;

    localparam logic [15:0] READER_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] requester;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  who;
        logic        woken_as_writer;
        logic        last;
        logic [15:0] readers_now;
        logic        writer_now;
    } out_item_t;

    typedef struct packed {
        logic inc;
        logic dec;
        logic set_wr;
        logic clr_wr;
    } hold_op_t;

    typedef struct packed {
        logic zero;
        logic one;
        logic sat;
        logic wr;
    } hold_stat_t;

    typedef struct packed {
        logic push;
        logic push_writer;
        logic pop;
    } q_op_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
        logic head_writer;
        logic next_writer;
    } q_stat_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_WAKE = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

endpackage

// ----- sv/rwl_holder.sv -----
// ----------------------------------------------------------------------------
// rwl_holder: lock holder state
// Keeps the reader count and the writer flag. One shared incrementer and
// decrementer serves read grants, unlocks and readers woken from the queue.
// ----------------------------------------------------------------------------
module rwl_holder
    import rwl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  hold_op_t    op,
    output logic [15:0] cnt_next,
    output logic        wr_next,
    output hold_stat_t  stat
);

    logic [15:0] cnt_reg;
    logic        wr_reg;
    logic [15:0] delta;
    logic [15:0] sum;

    assign delta    = op.dec ? 16'hFFFF : 16'd1;
    assign sum      = cnt_reg + delta;
    assign cnt_next = (op.inc || op.dec) ? sum : cnt_reg;
    assign wr_next  = op.set_wr ? 1'b1 : (op.clr_wr ? 1'b0 : wr_reg);

    assign stat.zero = (cnt_reg == 16'd0);
    assign stat.one  = (cnt_reg == 16'd1);
    assign stat.sat  = (cnt_reg == READER_MAX);
    assign stat.wr   = wr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 16'd0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            wr_reg  <= wr_next;
        end
    end

endmodule

// ----- sv/rwl_queue.sv -----
// ----------------------------------------------------------------------------
// rwl_queue: FIFO of blocked requesters
// A circular memory of requester identifiers with writer marks. The head
// entry and the writer mark of the entry behind it are read into registers.
// ----------------------------------------------------------------------------
module rwl_queue
    import rwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_KEEP     = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  q_op_t              op,
    input  logic [ID_KEEP-1:0] push_id,
    output logic [ID_KEEP-1:0] head_id,
    output q_stat_t            stat
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_T = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [AW:0]   DEPTH_H = (AW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [ID_KEEP:0]   mem [QUEUE_DEPTH];
    logic [AW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;
    logic [ID_KEEP:0]   rd_head_reg;
    logic               rd_next_wr_reg;
    logic [CW:0]        tail_sum;
    logic [CW:0]        tail_wrap;
    logic [AW-1:0]      tail;
    logic [AW:0]        head_sum;
    logic [AW-1:0]      head_inc;

    always_comb begin
        tail_sum  = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
        tail_wrap = (tail_sum >= DEPTH_T) ? (tail_sum - DEPTH_T) : tail_sum;
        tail      = tail_wrap[AW-1:0];
        head_sum  = (AW + 1)'(head_reg) + (AW + 1)'(1);
        head_inc  = (head_sum == DEPTH_H) ? '0 : head_sum[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (op.push) begin
                count_reg <= count_reg + CW'(1);
            end else if (op.pop) begin
                count_reg <= count_reg - CW'(1);
                head_reg  <= head_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op.push) begin
            mem[tail] <= {op.push_writer, push_id};
        end
        rd_head_reg    <= mem[head_reg];
        rd_next_wr_reg <= mem[head_inc][ID_KEEP];
    end

    assign head_id          = rd_head_reg[ID_KEEP-1:0];
    assign stat.head_writer = rd_head_reg[ID_KEEP];
    assign stat.next_writer = rd_next_wr_reg;
    assign stat.empty       = (count_reg == '0);
    assign stat.full        = (count_reg == DEPTH_C);
    assign stat.one         = (count_reg == CW'(1));

endmodule

// ----- sv/rwlock_fifo_arbiter.sv -----
// ----------------------------------------------------------------------------
// rwlock_fifo_arbiter: reader-writer lock arbiter with a FIFO of waiters
// Grants read and write locks, queues requesters that must wait and, when
// the lock falls free, wakes readers from the head up to the first writer.
//
//   Channel  Ports                        Carries
//   input    s_valid, s_ready, s_item     one lock, write-lock or unlock item
//   result   m_valid, m_ready, m_item     one or more events per input item
//
// An item is taken in the idle state and decided in the execute state once
// the result register is free. An unlock that wakes waiters goes from the
// execute state straight to the first wake, and each further wake passes
// through a wait state for the registered read of the queue memory.
// Reset clears the holder state and empties the queue; no clearing pass.
// A stalled result channel holds the sequencer before its next result.
// ----------------------------------------------------------------------------
module rwlock_fifo_arbiter
    import rwl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int ID_KEEP = (ID_WIDTH < 8) ? ID_WIDTH : 8;

    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         cmd_reg;
    logic [ID_KEEP-1:0] id_reg;
    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      n_next;
    logic               m_valid_reg;
    out_item_t          out_reg;
    out_item_t          out_new;
    logic               emit;
    logic               out_free;

    hold_op_t           h_op;
    hold_stat_t         h_stat;
    logic [15:0]        cnt_next;
    logic               wr_next;
    q_op_t              q_op;
    q_stat_t            q_stat;
    logic [ID_KEEP-1:0] head_id;

    rwl_holder u_holder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (h_op),
        .cnt_next (cnt_next),
        .wr_next  (wr_next),
        .stat     (h_stat)
    );

    rwl_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_KEEP     (ID_KEEP)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (q_op),
        .push_id (id_reg),
        .head_id (head_id),
        .stat    (q_stat)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = out_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        n_next      = n_reg;
        emit        = 1'b0;
        h_op        = '0;
        q_op        = '0;
        out_new.event_res       = EV_RELEASED;
        out_new.who             = 8'(id_reg);
        out_new.woken_as_writer = 1'b0;
        out_new.last            = 1'b1;
        out_new.readers_now     = cnt_next;
        out_new.writer_now      = wr_next;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                n_next = '0;
                if (cmd_reg inside {CMD_READ, CMD_WRITE, CMD_UNLOCK}) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        case (cmd_reg)
                            CMD_READ: begin
                                if (h_stat.wr) begin
                                    q_op.push         = !q_stat.full;
                                    out_new.event_res = q_stat.full ? EV_FULL : EV_QUEUED;
                                end else if (h_stat.sat) begin
                                    out_new.event_res = EV_SATURATED;
                                end else begin
                                    h_op.inc          = 1'b1;
                                    out_new.event_res = EV_GRANTED;
                                end
                            end
                            CMD_WRITE: begin
                                if (h_stat.wr || !h_stat.zero) begin
                                    q_op.push         = !q_stat.full;
                                    q_op.push_writer  = 1'b1;
                                    out_new.event_res = q_stat.full ? EV_FULL : EV_QUEUED;
                                end else begin
                                    h_op.set_wr             = 1'b1;
                                    out_new.event_res       = EV_GRANTED;
                                    out_new.woken_as_writer = 1'b1;
                                end
                            end
                            default: begin
                                if (!h_stat.zero) begin
                                    h_op.dec = 1'b1;
                                end else if (h_stat.wr) begin
                                    h_op.clr_wr = 1'b1;
                                end else begin
                                    out_new.event_res = EV_NO_HOLDER;
                                end
                                if ((h_stat.one || (h_stat.zero && h_stat.wr))
                                    && !q_stat.empty) begin
                                    emit       = 1'b0;
                                    state_next = S_WAKE;
                                end
                            end
                        endcase
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_WAKE: begin
                if (out_free) begin
                    emit              = 1'b1;
                    q_op.pop          = 1'b1;
                    out_new.event_res = EV_WOKEN;
                    out_new.who       = 8'(head_id);
                    n_next            = n_reg + NW'(1);
                    if (q_stat.head_writer) begin
                        h_op.set_wr             = 1'b1;
                        out_new.woken_as_writer = 1'b1;
                        out_new.last            = 1'b1;
                    end else begin
                        h_op.inc     = 1'b1;
                        out_new.last = q_stat.one || q_stat.next_writer
                                       || (n_reg == NW'(MAX_RESULTS - 1));
                    end
                    state_next = out_new.last ? S_IDLE : S_WAIT;
                end
            end
            S_WAIT: begin
                state_next = S_WAKE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_item.cmd;
            id_reg  <= s_item.requester[ID_KEEP-1:0];
        end
        if (emit) begin
            out_reg <= out_new;
        end
    end

    a_writer_excludes_readers: assert property (@(posedge aclk) disable iff (!aresetn)
        h_stat.wr |-> h_stat.zero)
        else $error("writer holds the lock while readers are counted");

    a_wake_needs_waiter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WAKE) |-> !q_stat.empty)
        else $error("wake step entered with an empty queue");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result register overwritten before it was taken");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && out_new.last) |=> (state_reg == S_IDLE))
        else $error("sequencer continued after the final result of an item");

    a_wake_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WAKE) |-> (n_reg < NW'(MAX_RESULTS)))
        else $error("unlock woke more waiters than allowed");

endmodule
